>>> src/assert_macros.svh
// Assertion macros used by the RTL top level.
// Both macros expect a clock named clk; MTP_ASSERT also expects a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define MTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define MTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/mtp_pkg.sv
// ---------------------------------------------------------------------------
// Minutiae template parser package
// Result codes, parse phases, header constants and the result word type.
// ---------------------------------------------------------------------------
package mtp_pkg;

  typedef enum logic [1:0] {
    KIND_MINUTIA    = 2'd0,
    KIND_EMPTY_VIEW = 2'd1,
    KIND_ERROR      = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_FORMAT_ID = 2'd0,
    ERR_VERSION   = 2'd1,
    ERR_EMPTY     = 2'd2
  } err_code_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_LONGLEN = 5'b00100,
    PH_SKIP    = 5'b01000,
    PH_MINUT   = 5'b10000
  } phase_t;

  localparam int unsigned HDR_LEN = 8;

  // Format identifier "FMR\0" followed by version " 20\0".
  localparam logic [7:0] HDR_BYTES [HDR_LEN] = '{
    8'h46, 8'h4D, 8'h52, 8'h00, 8'h20, 8'h32, 8'h30, 8'h00
  };

  localparam logic [5:0]  OFF_SHORT_LEN_HI = 6'd8;
  localparam logic [5:0]  OFF_VERSION      = 6'd4;
  localparam logic [5:0]  LONG_LEN_BYTES   = 6'd4;
  localparam logic [5:0]  SKIP_COUNT_AT    = 6'd19;
  localparam logic [31:0] EMPTY_LENGTH     = 32'd32;
  localparam logic [7:0]  COORD_HI_MASK    = 8'h3F;

  typedef struct packed {
    kind_t       kind;
    err_code_t   error_code;
    logic [13:0] x_position;
    logic [13:0] y_position;
    logic [7:0]  direction;
    logic [7:0]  minutia_index;
    logic        last;
  } result_t;

  localparam result_t RESULT_ZERO = '{
    kind: KIND_MINUTIA, error_code: ERR_FORMAT_ID, x_position: 14'd0,
    y_position: 14'd0, direction: 8'd0, minutia_index: 8'd0, last: 1'b0
  };

endpackage

>>> src/mtp_if.sv
// ---------------------------------------------------------------------------
// Minutiae template parser channels
// Byte input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface mtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface mtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic [13:0] x_position;
  logic [13:0] y_position;
  logic [7:0]  direction;
  logic [7:0]  minutia_index;
  logic        last;

  modport source (output valid, output kind, output error_code, output x_position,
                  output y_position, output direction, output minutia_index,
                  output last, input ready);
  modport sink   (input valid, input kind, input error_code, input x_position,
                  input y_position, input direction, input minutia_index,
                  input last, output ready);
endinterface

>>> src/mtp_parser.sv
// ---------------------------------------------------------------------------
// Minutiae template parser state machine
// Updates the parse state on each accepted byte and forms at most one result.
// ---------------------------------------------------------------------------
module mtp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             record_start,
  output logic             res_valid,
  output mtp_pkg::result_t res
);
  import mtp_pkg::*;

  phase_t      parse_phase, parse_phase_next;
  logic [5:0]  byte_offset, byte_offset_next;
  logic [31:0] record_length, record_length_next;
  logic [7:0]  minutia_count, minutia_count_next;
  logic [7:0]  current_index, current_index_next;
  logic [2:0]  byte_in_minutia, byte_in_minutia_next;
  logic [13:0] partial_x, partial_x_next;
  logic [13:0] partial_y, partial_y_next;
  logic [7:0]  partial_direction, partial_direction_next;

  logic [8:0]  index_inc;
  logic        is_last;
  logic [31:0] short_length;

  // A start byte sees the state cleared as after a reset, but with the phase set to header.
  always_comb begin
    if (record_start) begin
      parse_phase_next       = PH_HEADER;
      byte_offset_next       = 6'd0;
      record_length_next     = 32'd0;
      minutia_count_next     = 8'd0;
      current_index_next     = 8'd0;
      byte_in_minutia_next   = 3'd0;
      partial_x_next         = 14'd0;
      partial_y_next         = 14'd0;
      partial_direction_next = 8'd0;
    end else begin
      parse_phase_next       = parse_phase;
      byte_offset_next       = byte_offset;
      record_length_next     = record_length;
      minutia_count_next     = minutia_count;
      current_index_next     = current_index;
      byte_in_minutia_next   = byte_in_minutia;
      partial_x_next         = partial_x;
      partial_y_next         = partial_y;
      partial_direction_next = partial_direction;
    end

    res_valid    = 1'b0;
    res          = RESULT_ZERO;
    index_inc    = {1'b0, current_index_next} + 9'd1;
    is_last      = (index_inc >= {1'b0, minutia_count_next});
    short_length = {16'd0, record_length_next[7:0], data_byte};

    unique case (parse_phase_next)
      PH_HEADER: begin
        if (byte_offset_next < OFF_SHORT_LEN_HI) begin
          if (data_byte != HDR_BYTES[byte_offset_next[2:0]]) begin
            parse_phase_next = PH_IDLE;
            res_valid        = 1'b1;
            res.kind         = KIND_ERROR;
            res.error_code   = (byte_offset_next < OFF_VERSION) ? ERR_FORMAT_ID
                                                                : ERR_VERSION;
            res.last         = 1'b1;
          end else begin
            byte_offset_next = byte_offset_next + 6'd1;
          end
        end else if (byte_offset_next == OFF_SHORT_LEN_HI) begin
          record_length_next = {24'd0, data_byte};
          byte_offset_next   = OFF_SHORT_LEN_HI + 6'd1;
        end else if (record_length_next == 32'd0 && data_byte == 8'd0) begin
          // Two zero bytes announce the long length form.
          parse_phase_next   = PH_LONGLEN;
          byte_offset_next   = 6'd0;
          record_length_next = 32'd0;
        end else begin
          record_length_next = short_length;
          if (short_length == EMPTY_LENGTH) begin
            parse_phase_next = PH_IDLE;
            res_valid        = 1'b1;
            res.kind         = KIND_ERROR;
            res.error_code   = ERR_EMPTY;
            res.last         = 1'b1;
          end else begin
            parse_phase_next = PH_SKIP;
            byte_offset_next = 6'd0;
          end
        end
      end
      PH_LONGLEN: begin
        record_length_next = {record_length_next[23:0], data_byte};
        byte_offset_next   = byte_offset_next + 6'd1;
        if (byte_offset_next >= LONG_LEN_BYTES) begin
          if (record_length_next == EMPTY_LENGTH) begin
            parse_phase_next = PH_IDLE;
            res_valid        = 1'b1;
            res.kind         = KIND_ERROR;
            res.error_code   = ERR_EMPTY;
            res.last         = 1'b1;
          end else begin
            parse_phase_next = PH_SKIP;
            byte_offset_next = 6'd0;
          end
        end
      end
      PH_SKIP: begin
        if (byte_offset_next < SKIP_COUNT_AT) begin
          byte_offset_next = byte_offset_next + 6'd1;
        end else begin
          minutia_count_next   = data_byte;
          current_index_next   = 8'd0;
          byte_in_minutia_next = 3'd0;
          if (data_byte == 8'd0) begin
            parse_phase_next = PH_IDLE;
            res_valid        = 1'b1;
            res.kind         = KIND_EMPTY_VIEW;
            res.last         = 1'b1;
          end else begin
            parse_phase_next = PH_MINUT;
          end
        end
      end
      PH_MINUT: begin
        byte_in_minutia_next = byte_in_minutia_next + 3'd1;
        case (byte_in_minutia)
          3'd0: partial_x_next = {data_byte[5:0] & COORD_HI_MASK[5:0], 8'd0};
          3'd1: partial_x_next = {partial_x_next[13:8], data_byte};
          3'd2: partial_y_next = {data_byte[5:0] & COORD_HI_MASK[5:0], 8'd0};
          3'd3: partial_y_next = {partial_y_next[13:8], data_byte};
          3'd4: partial_direction_next = data_byte;
          default: begin
            res_valid            = 1'b1;
            res.kind             = KIND_MINUTIA;
            res.x_position       = partial_x_next;
            res.y_position       = partial_y_next;
            res.direction        = partial_direction_next;
            res.minutia_index    = current_index_next;
            res.last             = is_last;
            byte_in_minutia_next = 3'd0;
            current_index_next   = index_inc[7:0];
            if (is_last) begin
              parse_phase_next = PH_IDLE;
            end
          end
        endcase
      end
      default: begin
        parse_phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_IDLE;
      byte_offset       <= 6'd0;
      record_length     <= 32'd0;
      minutia_count     <= 8'd0;
      current_index     <= 8'd0;
      byte_in_minutia   <= 3'd0;
      partial_x         <= 14'd0;
      partial_y         <= 14'd0;
      partial_direction <= 8'd0;
    end else if (step) begin
      parse_phase       <= parse_phase_next;
      byte_offset       <= byte_offset_next;
      record_length     <= record_length_next;
      minutia_count     <= minutia_count_next;
      current_index     <= current_index_next;
      byte_in_minutia   <= byte_in_minutia_next;
      partial_x         <= partial_x_next;
      partial_y         <= partial_y_next;
      partial_direction <= partial_direction_next;
    end
  end

endmodule

>>> src/mtp_out_reg.sv
// ---------------------------------------------------------------------------
// Minutiae template parser result register
// Holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module mtp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  mtp_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             can_load,
  output mtp_pkg::result_t held
);
  import mtp_pkg::*;

  logic valid;

  // A new word may enter when the register is empty or is being emptied.
  assign can_load  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

>>> src/minutiae_template_parser_top.sv
// A result appears on the output channel in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the only stall is a full result register not taken.
// Each byte updates the parse state in one pass of logic; results pass one output register.
// Reset (rst, synchronous, active high) returns the parser to idle and empties the output.
// Bytes before the first record_start are consumed without result.
// ---------------------------------------------------------------------------
// Minutiae template parser top level
// Byte-wide minutiae record parser with a registered result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module minutiae_template_parser_top (
  input  logic  clk,
  input  logic  rst,
  mtp_in_if.sink     in_ch,
  mtp_out_if.source  out_ch
);
  import mtp_pkg::*;

  logic    step;
  logic    res_valid;
  logic    can_load;
  result_t res;
  result_t held;

  assign in_ch.ready = can_load;
  assign step        = in_ch.valid && can_load;

  mtp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (in_ch.data_byte),
    .record_start (in_ch.record_start),
    .res_valid    (res_valid),
    .res          (res)
  );

  mtp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .can_load  (can_load),
    .held      (held)
  );

  assign out_ch.kind          = held.kind;
  assign out_ch.error_code    = held.error_code;
  assign out_ch.x_position    = held.x_position;
  assign out_ch.y_position    = held.y_position;
  assign out_ch.direction     = held.direction;
  assign out_ch.minutia_index = held.minutia_index;
  assign out_ch.last          = held.last;

  `MTP_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !out_ch.valid, "output valid after reset")
  `MTP_ASSERT(a_ready_when_empty, !out_ch.valid |-> in_ch.ready, "input stalled with empty output")
  `MTP_ASSERT(a_drain_without_load, (out_ch.valid && out_ch.ready && !(in_ch.valid && in_ch.ready)) |=> !out_ch.valid, "word repeated after hand-over")
  `MTP_ASSERT(a_error_is_last, (out_ch.valid && (out_ch.kind == KIND_ERROR || out_ch.kind == KIND_EMPTY_VIEW)) |-> out_ch.last, "terminal word without last")
  `MTP_ASSERT(a_code_only_on_error, (out_ch.valid && out_ch.kind != KIND_ERROR) |-> (out_ch.error_code == ERR_FORMAT_ID), "error code on non-error word")

endmodule

>>> sim/mtp_result_checker.sv
// ---------------------------------------------------------------------------
// Minutiae template parser result checker
// Watches both channels, runs a byte-level model of the record parser on every
// accepted input word and compares each accepted result word with the oldest
// expected one, field by field.
// ---------------------------------------------------------------------------
module mtp_result_checker
  import mtp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mtp_in_if    in_mon,
  mtp_out_if   out_mon,
  output int   fail_count,
  output int   results_outstanding
);

  result_t     expected_results [$];

  phase_t      phase;
  logic [5:0]  ofs;
  logic [31:0] rec_len;
  logic [7:0]  m_count;
  logic [7:0]  m_index;
  logic [2:0]  m_byte;
  logic [13:0] px;
  logic [13:0] py;
  logic [7:0]  pdir;

  task report(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task clear_state();
    phase   = PH_IDLE;
    ofs     = '0;
    rec_len = '0;
    m_count = '0;
    m_index = '0;
    m_byte  = '0;
    px      = '0;
    py      = '0;
    pdir    = '0;
  endtask

  // A length of exactly 32 bytes leaves no room for a view.
  task close_length(inout result_t res, inout logic emit);
    if (rec_len == EMPTY_LENGTH) begin
      phase          = PH_IDLE;
      emit           = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = ERR_EMPTY;
      res.last       = 1'b1;
    end else begin
      phase = PH_SKIP;
      ofs   = '0;
    end
  endtask

  task parse_byte(input logic [7:0] b, input logic st);
    result_t res;
    logic    emit;
    logic    is_last;
    res  = RESULT_ZERO;
    emit = 1'b0;
    if (st) begin
      clear_state();
      phase = PH_HEADER;
    end
    case (phase)
      PH_HEADER: begin
        if (ofs < HDR_LEN) begin
          if (b != HDR_BYTES[ofs[2:0]]) begin
            phase          = PH_IDLE;
            emit           = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = (ofs < OFF_VERSION) ? ERR_FORMAT_ID : ERR_VERSION;
            res.last       = 1'b1;
          end else begin
            ofs = ofs + 6'd1;
          end
        end else if (ofs == OFF_SHORT_LEN_HI) begin
          rec_len = {24'd0, b};
          ofs     = OFF_SHORT_LEN_HI + 6'd1;
        end else if (rec_len == 32'd0 && b == 8'd0) begin
          // Two zero bytes announce the four-byte length form.
          phase   = PH_LONGLEN;
          ofs     = '0;
          rec_len = '0;
        end else begin
          rec_len = {16'd0, rec_len[7:0], b};
          close_length(res, emit);
        end
      end
      PH_LONGLEN: begin
        rec_len = {rec_len[23:0], b};
        ofs     = ofs + 6'd1;
        if (ofs >= LONG_LEN_BYTES) close_length(res, emit);
      end
      PH_SKIP: begin
        if (ofs < SKIP_COUNT_AT) begin
          ofs = ofs + 6'd1;
        end else begin
          m_count = b;
          m_index = '0;
          m_byte  = '0;
          if (b == 8'd0) begin
            phase    = PH_IDLE;
            emit     = 1'b1;
            res.kind = KIND_EMPTY_VIEW;
            res.last = 1'b1;
          end else begin
            phase = PH_MINUT;
          end
        end
      end
      PH_MINUT: begin
        case (m_byte)
          3'd0: px = {b[5:0], 8'd0};
          3'd1: px = {px[13:8], b};
          3'd2: py = {b[5:0], 8'd0};
          3'd3: py = {py[13:8], b};
          3'd4: pdir = b;
          default: begin
            is_last           = ({1'b0, m_index} + 9'd1) >= {1'b0, m_count};
            emit              = 1'b1;
            res.kind          = KIND_MINUTIA;
            res.x_position    = px;
            res.y_position    = py;
            res.direction     = pdir;
            res.minutia_index = m_index;
            res.last          = is_last;
            m_index           = m_index + 8'd1;
            if (is_last) phase = PH_IDLE;
          end
        endcase
        // The sixth byte closes the minutia and wraps the byte counter.
        m_byte = (m_byte == 3'd5) ? 3'd0 : m_byte + 3'd1;
      end
      default: ;
    endcase
    if (emit) expected_results = {expected_results, res};
  endtask

  task check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result word with nothing expected (kind %0d)", out_mon.kind));
    end else begin
      want = expected_results.pop_front();
      if (out_mon.kind !== want.kind)
        report($sformatf("kind got %0d expected %0d", out_mon.kind, want.kind));
      if (out_mon.error_code !== want.error_code)
        report($sformatf("error_code got %0d expected %0d", out_mon.error_code,
                         want.error_code));
      if (out_mon.x_position !== want.x_position)
        report($sformatf("x_position got %0d expected %0d", out_mon.x_position,
                         want.x_position));
      if (out_mon.y_position !== want.y_position)
        report($sformatf("y_position got %0d expected %0d", out_mon.y_position,
                         want.y_position));
      if (out_mon.direction !== want.direction)
        report($sformatf("direction got %0d expected %0d", out_mon.direction,
                         want.direction));
      if (out_mon.minutia_index !== want.minutia_index)
        report($sformatf("minutia_index got %0d expected %0d", out_mon.minutia_index,
                         want.minutia_index));
      if (out_mon.last !== want.last)
        report($sformatf("last got %0d expected %0d", out_mon.last, want.last));
    end
  endtask

  initial begin
    fail_count          = 0;
    results_outstanding = 0;
    clear_state();
  end

  // A result word taken at this edge stems from an earlier input word, so it
  // is checked before the input word of the same edge is modelled.
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.data_byte, in_mon.record_start);
    end
    results_outstanding <= expected_results.size();
  end

endmodule

>>> sim/minutiae_template_parser_top_tb.sv
// ---------------------------------------------------------------------------
// Minutiae template parser testbench
// Feeds directed error records and then randomised template records, mostly
// well formed with random content, some corrupted, cut short or trailed by
// stray bytes, with random gaps on both channels and two long receiver stalls.
// ---------------------------------------------------------------------------
module minutiae_template_parser_top_tb;
  import mtp_pkg::*;

  localparam int RANDOM_BYTES = 1450;
  localparam int BIG_RECORD_AT = 6;
  localparam int BIG_COUNT = 150;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int   fail_count;
  int   results_outstanding;
  int   bytes_sent = 0;
  int   idle_cycles = 0;
  bit   send_gaps = 1'b1;
  bit   recv_gaps = 1'b1;

  logic [7:0] rec [$];

  mtp_in_if  in_ch ();
  mtp_out_if out_ch ();

  minutiae_template_parser_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mtp_result_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .in_mon              (in_ch),
    .out_mon             (out_ch),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding)
  );

  initial forever #1 clk = ~clk;

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task add_byte(input logic [7:0] b);
    rec = {rec, b};
  endtask

  task send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = send_gaps ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.record_start <= st;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (bytes_sent % 64 == 0) send_gaps = ($urandom_range(0, 2) != 0);
  endtask

  task send_prefix(input int n);
    for (int i = 0; i < n; i++) send_byte(rec[i], i == 0);
  endtask

  // A forced count builds a clean record with that many minutiae.
  task build_record(input int forced);
    int sel;
    int cnt;
    int pos;
    rec.delete();
    for (int i = 0; i < HDR_LEN; i++) add_byte(HDR_BYTES[i]);
    if (forced < 0 && $urandom_range(0, 99) < 8) begin
      pos      = $urandom_range(0, HDR_LEN - 1);
      rec[pos] = rec[pos] ^ 8'($urandom_range(1, 255));
    end
    sel = (forced < 0) ? $urandom_range(0, 99) : 99;
    if (sel < 6) begin
      add_byte(8'h00);
      add_byte(8'(EMPTY_LENGTH));
    end else if (sel < 10) begin
      repeat (5) add_byte(8'h00);
      add_byte(8'(EMPTY_LENGTH));
    end else if (sel < 30) begin
      repeat (2) add_byte(8'h00);
      repeat (4) add_byte(pick_byte());
    end else begin
      repeat (2) add_byte(pick_byte());
    end
    repeat (SKIP_COUNT_AT) add_byte(pick_byte());
    if (forced >= 0) cnt = forced;
    else begin
      sel = $urandom_range(0, 99);
      cnt = (sel < 10) ? 0 : (sel < 95) ? $urandom_range(1, 6) : $urandom_range(7, 40);
    end
    add_byte(8'(cnt));
    repeat (cnt * 6) add_byte(pick_byte());
  endtask

  task send_record();
    int n;
    build_record(-1);
    n = rec.size();
    // Cutting a record short makes the next start land in mid record.
    if ($urandom_range(0, 99) < 8) n = $urandom_range(1, rec.size() - 1);
    send_prefix(n);
    if ($urandom_range(0, 99) < 6) repeat ($urandom_range(1, 5)) send_byte(pick_byte(), 1'b0);
  endtask

  // Stimulus.
  initial begin
    int base;
    int rec_no;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.record_start = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Stray bytes before any start.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Bad format identifier on its last byte.
    rec = '{8'h46, 8'h4D, 8'h52, 8'h01};
    send_prefix(rec.size());
    // Bad version on its first byte, then a byte that must be ignored.
    rec = '{8'h46, 8'h4D, 8'h52, 8'h00, 8'h21};
    send_prefix(rec.size());
    send_byte(8'h20, 1'b0);
    // Empty template: short length of 32.
    rec = '{8'h46, 8'h4D, 8'h52, 8'h00, 8'h20, 8'h32, 8'h30, 8'h00, 8'h00, 8'h20};
    send_prefix(rec.size());

    base   = bytes_sent;
    rec_no = 0;
    while (bytes_sent - base < RANDOM_BYTES) begin
      if (rec_no == BIG_RECORD_AT) begin
        // One long view carries a large minutia count and index.
        build_record(BIG_COUNT);
        send_prefix(rec.size());
      end else begin
        send_record();
      end
      rec_no++;
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (results_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus long stalls that fill the block.
  initial begin
    int wait_n;
    int taken;
    taken        = 0;
    out_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      wait_n = recv_gaps ? $urandom_range(0, 14) : 0;
      if (taken == 30 || taken == 200) wait_n = HOLD_CYCLES;
      repeat (wait_n) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken % 16 == 0) recv_gaps = ($urandom_range(0, 2) != 0);
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
